### rtl/core/hem_pkg.sv
// ----------------------------------------------------------------------------
// hem_pkg
// Shared types, constants and helper functions of the haptic effect mixer.
// ----------------------------------------------------------------------------
package hem_pkg;

    localparam int EFFECT_SLOTS = 16;
    localparam int SLOT_W       = (EFFECT_SLOTS > 1) ? $clog2(EFFECT_SLOTS) : 1;
    localparam int LEN_W        = 21;
    localparam int LVL_W        = 16;
    localparam int TIME_W       = 32;
    localparam int LFSR_W       = 32;
    localparam int PROD_W       = 37;
    localparam int DIV_CNT_W    = $clog2(PROD_W + 1);
    localparam int CALC_W       = 24;

    localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h8020_0003;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_PAUSE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] KIND_FIRE     = 3'd0;
    localparam logic [2:0] KIND_RAMPUP   = 3'd1;
    localparam logic [2:0] KIND_RUMBLE   = 3'd2;
    localparam logic [2:0] KIND_BUZZ     = 3'd3;
    localparam logic [2:0] KIND_CONSTANT = 3'd4;
    localparam logic [2:0] KIND_DAMAGE   = 3'd5;

    localparam logic MOTOR_L = 1'b0;
    localparam logic MOTOR_R = 1'b1;

    localparam logic [9:0] HOLD_UPDATE = 10'd1000;
    localparam logic [9:0] HOLD_STOP   = 10'd0;

    localparam int FIRE_LEN_BASE = 175;
    localparam int FIRE_LEN_STEP = 20;
    localparam int FIRE_BASE     = 21000;
    localparam int FIRE_STEP     = 4400;
    localparam int RAMP_START    = 1000;
    localparam int RAMP_BASE     = 21000;
    localparam int RAMP_STEP     = 3100;
    localparam int NOISE_BASE    = 5000;
    localparam int NOISE_STEP    = 6700;
    localparam int CONST_STEP    = 6500;
    localparam int DMG_BASE      = 25000;
    localparam int DMG_STEP      = 400;
    localparam int DMG_END_NUM   = 40;
    localparam int DMG_END_SHIFT = 6;
    localparam int LVL_MAX       = 65535;

    localparam logic [4:0] CMD_NONE      = 5'd0;
    localparam logic [4:0] CMD_CAPTURE   = 5'd1;
    localparam logic [4:0] CMD_START     = 5'd2;
    localparam logic [4:0] CMD_CLEAR     = 5'd3;
    localparam logic [4:0] CMD_PAUSE_SET = 5'd4;
    localparam logic [4:0] CMD_PAUSE_CLR = 5'd5;
    localparam logic [4:0] CMD_RES_ZERO  = 5'd6;
    localparam logic [4:0] CMD_ACC_CLR   = 5'd7;
    localparam logic [4:0] CMD_LOAD      = 5'd8;
    localparam logic [4:0] CMD_DROP      = 5'd9;
    localparam logic [4:0] CMD_ADD_A     = 5'd10;
    localparam logic [4:0] CMD_MUL_RAMP  = 5'd11;
    localparam logic [4:0] CMD_MUL_DMGL  = 5'd12;
    localparam logic [4:0] CMD_MUL_DMGR  = 5'd13;
    localparam logic [4:0] CMD_NOISE     = 5'd14;
    localparam logic [4:0] CMD_DIV_GO    = 5'd15;
    localparam logic [4:0] CMD_ADD_RAMP  = 5'd16;
    localparam logic [4:0] CMD_ADD_NOISE = 5'd17;
    localparam logic [4:0] CMD_ADD_DMGL  = 5'd18;
    localparam logic [4:0] CMD_ADD_HALF  = 5'd19;
    localparam logic [4:0] CMD_ADD_DMGR  = 5'd20;
    localparam logic [4:0] CMD_ADVANCE   = 5'd21;
    localparam logic [4:0] CMD_RES_UPD   = 5'd22;
    localparam logic [4:0] CMD_EMIT      = 5'd23;

    typedef struct packed {
        logic [1:0]        operation;
        logic [2:0]        effect_kind;
        logic [6:0]        effect_level;
        logic [15:0]       effect_length;
        logic              pause_on;
        logic [TIME_W-1:0] current_time;
    } item_t;

    typedef struct packed {
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic [9:0]  hold_ms;
    } result_t;

    typedef struct packed {
        logic [4:0] code;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       pause_on;
        logic       paused;
        logic       drop;
        logic       skip;
        logic [2:0] kind;
        logic       noise_on;
        logic       e_lt_half;
        logic       last;
        logic       div_done;
        logic       out_free;
    } ctl_stat_t;

    function automatic logic [LVL_W-1:0] sat16(input logic [CALC_W-1:0] v);
        sat16 = (v > CALC_W'(LVL_MAX)) ? LVL_W'(LVL_MAX) : v[LVL_W-1:0];
    endfunction

    function automatic logic [LVL_W-1:0] sat_add(input logic [LVL_W-1:0] acc,
                                                 input logic [LVL_W-1:0] v);
        logic [LVL_W:0] s;
        s = {1'b0, acc} + {1'b0, v};
        sat_add = s[LVL_W] ? LVL_W'(LVL_MAX) : s[LVL_W-1:0];
    endfunction

endpackage

### rtl/core/hem_div.sv
// ----------------------------------------------------------------------------
// hem_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hem_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [hem_pkg::PROD_W-1:0] num,
    input  logic [hem_pkg::LEN_W-1:0]  den,
    output logic [hem_pkg::PROD_W-1:0] quot,
    output logic [hem_pkg::LEN_W-1:0]  rem,
    output logic                     done
);
    import hem_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    num_reg, num_next;
    logic [LEN_W-1:0]     den_reg, den_next;
    logic [LEN_W:0]       rem_reg, rem_next;
    logic [LEN_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[LEN_W-1:0], num_reg[PROD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(PROD_W);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                num_next = {num_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quot = num_reg;
    assign rem  = rem_reg[LEN_W-1:0];
    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

### rtl/core/hem_datapath.sv
// ----------------------------------------------------------------------------
// hem_datapath
// Slot table, effect arithmetic, noise generator, accumulators and result.
// ----------------------------------------------------------------------------
module hem_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  hem_pkg::item_t     item,
    input  hem_pkg::ctl_cmd_t  cmd,
    output hem_pkg::ctl_stat_t stat,
    output logic               result_valid,
    input  logic               result_ready,
    output hem_pkg::result_t   result
);
    import hem_pkg::*;

    item_t             in_reg;
    logic              paused_reg;
    logic [LFSR_W-1:0] lfsr_reg;

    logic              slot_valid_reg [EFFECT_SLOTS];
    logic [2:0]        slot_kind_reg  [EFFECT_SLOTS];
    logic              slot_motor_reg [EFFECT_SLOTS];
    logic [TIME_W-1:0] slot_start_reg [EFFECT_SLOTS];
    logic [LEN_W-1:0]  slot_len_reg   [EFFECT_SLOTS];
    logic [LVL_W-1:0]  slot_a_reg     [EFFECT_SLOTS];
    logic [LVL_W-1:0]  slot_b_reg     [EFFECT_SLOTS];

    logic [SLOT_W-1:0] idx_reg;
    logic              cur_valid_reg;
    logic              cur_exp_reg;
    logic [LEN_W-1:0]  e_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LVL_W-1:0]  a_reg;
    logic [LVL_W-1:0]  b_reg;
    logic [2:0]        kind_reg;
    logic              motor_reg;
    logic [PROD_W-1:0] num_reg;
    logic [LEN_W-1:0]  den_reg;
    logic [LVL_W-1:0]  acc_l_reg;
    logic [LVL_W-1:0]  acc_r_reg;
    result_t           res_reg;
    result_t           out_reg;
    logic              out_valid_reg;

    logic              keep [EFFECT_SLOTS];
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              kind_ok;
    logic [2:0]        new_kind;
    logic [6:0]        lvl;
    logic              new_motor;
    logic [LEN_W-1:0]  new_len;
    logic [LVL_W-1:0]  new_a;
    logic [LVL_W-1:0]  new_b;
    logic [CALC_W-1:0] fire_len;

    logic [TIME_W-1:0] e_full;
    logic [LVL_W-1:0]  ramp_diff;
    logic [LVL_W-1:0]  dmg_end;
    logic [CALC_W-1:0] dmg_prod;
    logic [LVL_W-1:0]  half;
    logic [LFSR_W-1:0] lfsr_nx;
    logic [PROD_W-1:0] div_quot;
    logic [LEN_W-1:0]  div_rem;
    logic              div_done;
    logic [LVL_W-1:0]  q16;
    logic [LVL_W-1:0]  ramp_val;

    hem_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.code == CMD_DIV_GO),
        .num   (num_reg),
        .den   (den_reg),
        .quot  (div_quot),
        .rem   (div_rem),
        .done  (div_done)
    );

    assign new_kind = in_reg.effect_kind;
    assign lvl      = in_reg.effect_level;
    assign kind_ok  = (new_kind == KIND_FIRE) || (new_kind == KIND_RAMPUP) ||
                      (new_kind == KIND_RUMBLE) || (new_kind == KIND_BUZZ) ||
                      (new_kind == KIND_CONSTANT) || (new_kind == KIND_DAMAGE);
    assign fire_len = CALC_W'(FIRE_LEN_BASE) +
                      CALC_W'(in_reg.effect_length) * CALC_W'(FIRE_LEN_STEP);

    always_comb
    begin
        new_motor = MOTOR_L;
        new_len   = LEN_W'(in_reg.effect_length);
        new_a     = '0;
        new_b     = '0;
        case (new_kind)
            KIND_FIRE:
            begin
                new_len = fire_len[LEN_W-1:0];
                new_a   = sat16(CALC_W'(FIRE_BASE) + CALC_W'(lvl) * CALC_W'(FIRE_STEP));
            end
            KIND_RAMPUP:
            begin
                new_motor = MOTOR_R;
                new_a     = LVL_W'(RAMP_START);
                new_b     = sat16(CALC_W'(RAMP_BASE) + CALC_W'(lvl) * CALC_W'(RAMP_STEP));
            end
            KIND_RUMBLE, KIND_BUZZ:
            begin
                new_motor = (new_kind == KIND_BUZZ) ? MOTOR_R : MOTOR_L;
                if (lvl != 7'd0)
                begin
                    new_b = sat16(CALC_W'(NOISE_BASE) +
                                  CALC_W'(lvl - 7'd1) * CALC_W'(NOISE_STEP));
                end
            end
            KIND_CONSTANT:
            begin
                new_motor = MOTOR_R;
                new_a     = sat16(CALC_W'(lvl) * CALC_W'(CONST_STEP));
            end
            KIND_DAMAGE:
            begin
                new_a = sat16(CALC_W'(DMG_BASE) + CALC_W'(lvl) * CALC_W'(DMG_STEP));
            end
            default:
            begin
                new_a = '0;
            end
        endcase
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < EFFECT_SLOTS; i++)
        begin
            keep[i] = slot_valid_reg[i] &&
                      !(new_kind == KIND_CONSTANT && slot_kind_reg[i] == KIND_CONSTANT);
        end
        for (int i = EFFECT_SLOTS - 1; i >= 0; i--)
        begin
            if (!keep[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign e_full    = in_reg.current_time - slot_start_reg[idx_reg];
    assign ramp_diff = (a_reg > b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
    assign dmg_prod  = CALC_W'(a_reg) * CALC_W'(DMG_END_NUM);
    assign dmg_end   = LVL_W'(dmg_prod >> DMG_END_SHIFT);
    assign half      = a_reg >> 1;
    assign lfsr_nx   = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
    assign q16       = div_quot[LVL_W-1:0];
    assign ramp_val  = (a_reg > b_reg) ? (a_reg - q16) : (a_reg + q16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg    <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < EFFECT_SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.code == CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.code)
                CMD_PAUSE_SET: paused_reg <= 1'b1;
                CMD_PAUSE_CLR: paused_reg <= 1'b0;
                CMD_NOISE:     lfsr_reg   <= lfsr_nx;
                CMD_CLEAR:
                begin
                    for (int i = 0; i < EFFECT_SLOTS; i++)
                    begin
                        slot_valid_reg[i] <= 1'b0;
                    end
                end
                CMD_START:
                begin
                    if (kind_ok)
                    begin
                        for (int i = 0; i < EFFECT_SLOTS; i++)
                        begin
                            slot_valid_reg[i] <= keep[i] ||
                                                 (free_found && (free_idx == SLOT_W'(i)));
                        end
                    end
                end
                CMD_DROP: slot_valid_reg[idx_reg] <= 1'b0;
                default:  paused_reg <= paused_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == CMD_START && kind_ok && free_found)
        begin
            slot_kind_reg[free_idx]  <= new_kind;
            slot_motor_reg[free_idx] <= new_motor;
            slot_start_reg[free_idx] <= in_reg.current_time;
            slot_len_reg[free_idx]   <= new_len;
            slot_a_reg[free_idx]     <= new_a;
            slot_b_reg[free_idx]     <= new_b;
        end
        if (cmd.code == CMD_EMIT)
        begin
            out_reg <= res_reg;
        end
        case (cmd.code)
            CMD_CAPTURE: in_reg <= item;
            CMD_ACC_CLR:
            begin
                idx_reg   <= '0;
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end
            CMD_LOAD:
            begin
                cur_valid_reg <= slot_valid_reg[idx_reg];
                cur_exp_reg   <= e_full > TIME_W'(slot_len_reg[idx_reg]);
                e_reg         <= e_full[LEN_W-1:0];
                len_reg       <= slot_len_reg[idx_reg];
                a_reg         <= slot_a_reg[idx_reg];
                b_reg         <= slot_b_reg[idx_reg];
                kind_reg      <= slot_kind_reg[idx_reg];
                motor_reg     <= slot_motor_reg[idx_reg];
            end
            CMD_ADVANCE: idx_reg <= idx_reg + 1'b1;
            CMD_MUL_RAMP:
            begin
                num_reg <= PROD_W'(ramp_diff) * PROD_W'(e_reg);
                den_reg <= len_reg;
            end
            CMD_MUL_DMGL:
            begin
                num_reg <= PROD_W'(a_reg - dmg_end) * PROD_W'(e_reg);
                den_reg <= len_reg;
            end
            CMD_MUL_DMGR:
            begin
                num_reg <= PROD_W'(half) * PROD_W'(e_reg);
                den_reg <= len_reg;
            end
            CMD_NOISE:
            begin
                num_reg <= PROD_W'(lfsr_nx);
                den_reg <= LEN_W'(b_reg - a_reg);
            end
            CMD_ADD_A:
            begin
                if (motor_reg == MOTOR_R)
                    acc_r_reg <= sat_add(acc_r_reg, a_reg);
                else
                    acc_l_reg <= sat_add(acc_l_reg, a_reg);
            end
            CMD_ADD_RAMP:
            begin
                if (motor_reg == MOTOR_R)
                    acc_r_reg <= sat_add(acc_r_reg, ramp_val);
                else
                    acc_l_reg <= sat_add(acc_l_reg, ramp_val);
            end
            CMD_ADD_NOISE:
            begin
                if (motor_reg == MOTOR_R)
                    acc_r_reg <= sat_add(acc_r_reg, a_reg + div_rem[LVL_W-1:0]);
                else
                    acc_l_reg <= sat_add(acc_l_reg, a_reg + div_rem[LVL_W-1:0]);
            end
            CMD_ADD_DMGL: acc_l_reg <= sat_add(acc_l_reg, a_reg - q16);
            CMD_ADD_HALF: acc_r_reg <= sat_add(acc_r_reg, half);
            CMD_ADD_DMGR: acc_r_reg <= sat_add(acc_r_reg, half - q16);
            CMD_RES_UPD:
            begin
                res_reg.left_speed  <= acc_l_reg;
                res_reg.right_speed <= acc_r_reg;
                res_reg.hold_ms     <= HOLD_UPDATE;
            end
            CMD_RES_ZERO, CMD_PAUSE_SET, CMD_CLEAR:
            begin
                res_reg.left_speed  <= '0;
                res_reg.right_speed <= '0;
                res_reg.hold_ms     <= HOLD_STOP;
            end
            default: ;
        endcase
    end

    assign stat.operation = in_reg.operation;
    assign stat.pause_on  = in_reg.pause_on;
    assign stat.paused    = paused_reg;
    assign stat.drop      = cur_valid_reg && cur_exp_reg;
    assign stat.skip      = !cur_valid_reg || (len_reg == '0);
    assign stat.kind      = kind_reg;
    assign stat.noise_on  = b_reg > a_reg;
    assign stat.e_lt_half = e_reg < (len_reg >> 1);
    assign stat.last      = idx_reg == SLOT_W'(EFFECT_SLOTS - 1);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_EMIT) |-> (!out_valid_reg || result_ready))
        else $error("result overwritten before transaction");

    a_rise_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.code == CMD_EMIT))
        else $error("result valid without emit");

endmodule

### rtl/core/hem_ctrl.sv
// ----------------------------------------------------------------------------
// hem_ctrl
// Sequencer: decodes items and walks the slot table on an update tick that is not paused.
// ----------------------------------------------------------------------------
module hem_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  hem_pkg::ctl_stat_t stat,
    output hem_pkg::ctl_cmd_t  cmd
);
    import hem_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SLOT   = 4'd2;
    localparam logic [3:0] S_EVAL   = 4'd3;
    localparam logic [3:0] S_GO     = 4'd4;
    localparam logic [3:0] S_WAIT   = 4'd5;
    localparam logic [3:0] S_DMGR   = 4'd6;
    localparam logic [3:0] S_NEXT   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam logic [1:0] JOB_RAMP  = 2'd0;
    localparam logic [1:0] JOB_NOISE = 2'd1;
    localparam logic [1:0] JOB_DMGL  = 2'd2;
    localparam logic [1:0] JOB_DMGR  = 2'd3;

    logic [3:0] state_reg, state_next;
    logic [1:0] job_reg, job_next;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cmd.code   = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.code   = CMD_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.operation)
                    OP_START:
                    begin
                        cmd.code   = CMD_START;
                        state_next = S_IDLE;
                    end
                    OP_UPDATE:
                    begin
                        if (stat.paused)
                        begin
                            cmd.code   = CMD_RES_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.code   = CMD_ACC_CLR;
                            state_next = S_SLOT;
                        end
                    end
                    OP_PAUSE:
                    begin
                        if (!stat.paused && stat.pause_on)
                        begin
                            cmd.code   = CMD_PAUSE_SET;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.code   = CMD_PAUSE_CLR;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.code   = CMD_CLEAR;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SLOT:
            begin
                cmd.code   = CMD_LOAD;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_NEXT;
                if (stat.drop)
                begin
                    cmd.code = CMD_DROP;
                end
                else if (!stat.skip)
                begin
                    case (stat.kind)
                        KIND_FIRE, KIND_RAMPUP:
                        begin
                            cmd.code   = CMD_MUL_RAMP;
                            job_next   = JOB_RAMP;
                            state_next = S_GO;
                        end
                        KIND_RUMBLE, KIND_BUZZ:
                        begin
                            if (stat.noise_on)
                            begin
                                cmd.code   = CMD_NOISE;
                                job_next   = JOB_NOISE;
                                state_next = S_GO;
                            end
                            else
                            begin
                                cmd.code = CMD_ADD_A;
                            end
                        end
                        KIND_CONSTANT: cmd.code = CMD_ADD_A;
                        KIND_DAMAGE:
                        begin
                            cmd.code   = CMD_MUL_DMGL;
                            job_next   = JOB_DMGL;
                            state_next = S_GO;
                        end
                        default: cmd.code = CMD_NONE;
                    endcase
                end
            end
            S_GO:
            begin
                cmd.code   = CMD_DIV_GO;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_NEXT;
                    case (job_reg)
                        JOB_RAMP:  cmd.code = CMD_ADD_RAMP;
                        JOB_NOISE: cmd.code = CMD_ADD_NOISE;
                        JOB_DMGL:
                        begin
                            cmd.code   = CMD_ADD_DMGL;
                            state_next = S_DMGR;
                        end
                        default:   cmd.code = CMD_ADD_DMGR;
                    endcase
                end
            end
            S_DMGR:
            begin
                if (stat.e_lt_half)
                begin
                    cmd.code   = CMD_ADD_HALF;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.code   = CMD_MUL_DMGR;
                    job_next   = JOB_DMGR;
                    state_next = S_GO;
                end
            end
            S_NEXT:
            begin
                if (stat.last)
                begin
                    cmd.code   = CMD_RES_UPD;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.code   = CMD_ADVANCE;
                    state_next = S_SLOT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.code   = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= JOB_RAMP;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction not decoded");

endmodule

### rtl/core/haptic_effect_mixer.sv
// ----------------------------------------------------------------------------
// haptic_effect_mixer
// Timed vibration effect table for two motors with per-tick mixing.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      hem_pkg::item_t
//   result    out        result_valid / result_ready  hem_pkg::result_t
//
// Start and resume return to idle after decoding; pause, clear and a paused tick
// also wait for the output register to be free.
// An update tick walks all 16 slots; a ramp or noise slot waits for one division
// and a damage slot for up to two on the serial divider that all slots share.
// Reset clears the valid bits and pause flag and seeds the noise register; no clearing pass.
// A waiting result holds in the output register; the next item is taken then.
// ----------------------------------------------------------------------------
module haptic_effect_mixer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  hem_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output hem_pkg::result_t result
);
    import hem_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    hem_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    hem_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### verif/hem_checker.sv
// ----------------------------------------------------------------------------
// hem_checker
// Watches the item and result channels of the haptic effect mixer, keeps a
// shadow slot table with its own noise register, predicts each result and
// compares the whole result with what the block delivers.
// ----------------------------------------------------------------------------
module hem_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  hem_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  hem_pkg::result_t result,
    output int               fail_count,
    output int               pending
);
    import hem_pkg::*;

    logic               sh_valid [EFFECT_SLOTS];
    logic [2:0]         sh_kind  [EFFECT_SLOTS];
    logic               sh_motor [EFFECT_SLOTS];
    logic [31:0]        sh_start [EFFECT_SLOTS];
    logic [31:0]        sh_len   [EFFECT_SLOTS];
    logic [15:0]        sh_a     [EFFECT_SLOTS];
    logic [15:0]        sh_b     [EFFECT_SLOTS];
    logic               sh_paused;
    logic [31:0]        sh_noise;
    result_t            mix_queue [$];

    function automatic logic [15:0] clip16(input longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [31:0] acc_add(input logic [31:0] acc,
                                            input logic [31:0] v);
        logic [31:0] s;
        s = acc + v;
        return (s > 65535) ? 32'd65535 : s;
    endfunction

    function automatic logic [31:0] slope(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] e, input logic [31:0] len);
        longint unsigned p;
        if (a > b)
        begin
            p = (longint'(a - b) * e) / len;
            return a - p[31:0];
        end
        p = (longint'(b - a) * e) / len;
        return a + p[31:0];
    endfunction

    task automatic start_effect(input item_t it);
        logic        motor;
        logic [31:0] a, b, len;
        int          slot;
        motor = MOTOR_L;
        a = 0;
        b = 0;
        len = it.effect_length;
        slot = -1;
        case (it.effect_kind)
            KIND_FIRE:
            begin
                len = 175 + 20 * len;
                a = clip16(21000 + 4400 * longint'(it.effect_level));
            end
            KIND_RAMPUP:
            begin
                motor = MOTOR_R;
                a = 1000;
                b = clip16(21000 + 3100 * longint'(it.effect_level));
            end
            KIND_RUMBLE, KIND_BUZZ:
            begin
                motor = (it.effect_kind == KIND_BUZZ) ? MOTOR_R : MOTOR_L;
                b = (it.effect_level == 0) ? 0
                    : clip16(5000 + 6700 * longint'(it.effect_level - 1));
            end
            KIND_CONSTANT:
            begin
                motor = MOTOR_R;
                a = clip16(6500 * longint'(it.effect_level));
                for (int i = 0; i < EFFECT_SLOTS; i++)
                    if (sh_valid[i] && sh_kind[i] == KIND_CONSTANT)
                        sh_valid[i] = 1'b0;
            end
            KIND_DAMAGE:
                a = clip16(25000 + 400 * longint'(it.effect_level));
            default:
                return;
        endcase
        for (int i = EFFECT_SLOTS - 1; i >= 0; i--)
            if (!sh_valid[i])
                slot = i;
        if (slot < 0)
            return;
        sh_valid[slot] = 1'b1;
        sh_kind[slot]  = it.effect_kind;
        sh_motor[slot] = motor;
        sh_start[slot] = it.current_time;
        sh_len[slot]   = len & 32'h1F_FFFF;
        sh_a[slot]     = a[15:0];
        sh_b[slot]     = b[15:0];
    endtask

    task automatic mix_slots(input logic [31:0] t, output result_t r);
        logic [31:0]     acc [2];
        logic [31:0]     e, len, a, b, v, endl, half;
        longint unsigned p;
        acc[0] = 0;
        acc[1] = 0;
        for (int i = 0; i < EFFECT_SLOTS; i++)
        begin
            if (!sh_valid[i])
                continue;
            e = t - sh_start[i];
            len = sh_len[i];
            if (e > len)
            begin
                sh_valid[i] = 1'b0;
                continue;
            end
            if (len == 0)
                continue;
            a = sh_a[i];
            b = sh_b[i];
            case (sh_kind[i])
                KIND_FIRE, KIND_RAMPUP:
                    acc[sh_motor[i]] = acc_add(acc[sh_motor[i]], slope(a, b, e, len));
                KIND_RUMBLE, KIND_BUZZ:
                begin
                    v = a;
                    if (b > a)
                    begin
                        sh_noise = sh_noise[0] ? ((sh_noise >> 1) ^ LFSR_MASK)
                                               : (sh_noise >> 1);
                        v = a + sh_noise % (b - a);
                    end
                    acc[sh_motor[i]] = acc_add(acc[sh_motor[i]], v);
                end
                KIND_CONSTANT:
                    acc[sh_motor[i]] = acc_add(acc[sh_motor[i]], a);
                KIND_DAMAGE:
                begin
                    endl = a * 40 / 64;
                    half = a / 2;
                    acc[0] = acc_add(acc[0], slope(a, endl, e, len));
                    if (e < len / 2)
                        v = half;
                    else
                    begin
                        p = (longint'(half) * e) / len;
                        v = half - p[31:0];
                    end
                    acc[1] = acc_add(acc[1], v);
                end
                default: ;
            endcase
        end
        r.left_speed  = acc[0][15:0];
        r.right_speed = acc[1][15:0];
        r.hold_ms     = HOLD_UPDATE;
    endtask

    task automatic predict_item(input item_t it);
        result_t r;
        r = '0;
        case (it.operation)
            OP_START:
                start_effect(it);
            OP_UPDATE:
            begin
                if (!sh_paused)
                    mix_slots(it.current_time, r);
                mix_queue.push_back(r);
            end
            OP_PAUSE:
                if (!sh_paused && it.pause_on)
                begin
                    sh_paused = 1'b1;
                    mix_queue.push_back(r);
                end
                else
                    sh_paused = 1'b0;
            default:
            begin
                for (int i = 0; i < EFFECT_SLOTS; i++)
                    sh_valid[i] = 1'b0;
                mix_queue.push_back(r);
            end
        endcase
    endtask

    assign pending = mix_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < EFFECT_SLOTS; i++)
                sh_valid[i] = 1'b0;
            sh_paused  = 1'b0;
            sh_noise   = LFSR_SEED;
            fail_count = 0;
            mix_queue.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (mix_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: %0d %0d %0d",
                                 result.left_speed, result.right_speed, result.hold_ms);
                end
                else
                begin
                    want = mix_queue.pop_front();
                    if (want !== result)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %0d %0d %0d act %0d %0d %0d",
                                     want.left_speed, want.right_speed, want.hold_ms,
                                     result.left_speed, result.right_speed,
                                     result.hold_ms);
                    end
                end
            end
            if (item_valid && item_ready)
                predict_item(item);
        end
    end
endmodule

### verif/tb_haptic_effect_mixer.sv
// ----------------------------------------------------------------------------
// tb_haptic_effect_mixer
// Drives directed and random effect traffic into the haptic effect mixer with
// random gaps and output stalls, one long stall to back the block up, and
// reports the verdict from the checker's failure count and pending results.
// ----------------------------------------------------------------------------
module tb_haptic_effect_mixer;
    import hem_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      fail_count;
    int      pending;
    logic    quiet;
    logic    long_hold;
    logic [31:0] now_ms;

    haptic_effect_mixer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    hem_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send(input item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    function automatic item_t make_item(input logic [1:0] op, input logic [2:0] kind,
                                        input logic [6:0] lvl, input logic [15:0] len,
                                        input logic pon, input logic [31:0] t);
        item_t it;
        it.operation     = op;
        it.effect_kind   = kind;
        it.effect_level  = lvl;
        it.effect_length = len;
        it.pause_on      = pon;
        it.current_time  = t;
        return it;
    endfunction

    function automatic logic [6:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd100;
            2:       return 7'd127;
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (long_hold)
            result_ready <= 1'b0;
        else if (quiet)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        long_hold = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        long_hold = 1'b1;
        repeat (4000) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        #200_000_000;
        $display("haptic_effect_mixer regression: fail");
        $finish;
    end

    initial
    begin
        item_t it;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        quiet      = 1'b0;
        now_ms     = 32'd100;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_item(OP_UPDATE, KIND_FIRE, 0, 0, 0, now_ms));
        for (int k = 0; k < 8; k++)
            send(make_item(OP_START, 3'(k), (k % 2) ? 7'd127 : 7'd0,
                           (k % 2) ? 16'hFFFF : 16'd0, 0, now_ms));
        send(make_item(OP_UPDATE, KIND_FIRE, 0, 0, 0, now_ms));
        send(make_item(OP_START, KIND_DAMAGE, 100, 50, 0, now_ms));
        send(make_item(OP_START, KIND_CONSTANT, 100, 1000, 0, now_ms));
        send(make_item(OP_UPDATE, KIND_FIRE, 0, 0, 0, now_ms + 30));
        send(make_item(OP_PAUSE, KIND_FIRE, 0, 0, 1, now_ms));
        send(make_item(OP_UPDATE, KIND_FIRE, 0, 0, 0, now_ms + 40));
        send(make_item(OP_PAUSE, KIND_FIRE, 0, 0, 1, now_ms));
        send(make_item(OP_PAUSE, KIND_FIRE, 0, 0, 0, now_ms));
        for (int k = 0; k < 18; k++)
            send(make_item(OP_START, KIND_BUZZ, 100, 16'hFFFF, 0, now_ms));
        send(make_item(OP_UPDATE, KIND_FIRE, 0, 0, 0, 32'hFFFF_FFFF));
        send(make_item(OP_UPDATE, KIND_FIRE, 0, 0, 0, now_ms + 100));
        send(make_item(OP_CLEAR, KIND_FIRE, 0, 0, 0, now_ms));
        now_ms = 32'hFFFF_FF00;

        for (int n = 0; n < 1000; n++)
        begin
            if (n == 900)
                quiet = 1'b1;
            it = '0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    it.operation     = OP_START;
                    it.effect_kind   = ($urandom_range(0, 15) == 0)
                                       ? 3'($urandom_range(6, 7))
                                       : 3'($urandom_range(0, 5));
                    it.effect_level  = pick_level();
                    it.effect_length = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(0, 400));
                end
                7, 8, 9, 10, 11, 12, 13, 14:
                    it.operation = OP_UPDATE;
                15, 16:
                    it.operation = OP_PAUSE;
                17:
                    it.operation = OP_CLEAR;
                default:
                begin
                    it = item_t'($bits(item_t)'({$urandom, $urandom}));
                end
            endcase
            if (it.operation != OP_START || $urandom_range(0, 1) == 0)
                it.pause_on = $urandom_range(0, 1);
            if ($urandom_range(0, 49) == 0)
                now_ms = $urandom;
            else
                now_ms = now_ms + $urandom_range(0, 40);
            if (n % 20 != 19)
                it.current_time = now_ms;
            send(it);
        end
        item_valid <= 1'b0;

        fork
            wait (pending == 0);
            repeat (200000) @(posedge clk);
        join_any
        disable fork;
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("haptic_effect_mixer regression: pass");
        else
            $display("haptic_effect_mixer regression: fail");
        $finish;
    end
endmodule
